/* sv/vt_pkg.sv */
// vt_pkg: shared types and constants for the vertex_transform_4x4 block.
// No dependencies; imported by every module of the block.
package vt_pkg;

  localparam int VT_FRAC_BITS = 16;   // default Q16.16
  localparam int VT_DIM       = 4;    // vector length / matrix order
  localparam int VT_WORD_W    = 32;
  localparam int VT_PROD_W    = 2 * VT_WORD_W;
  localparam int VT_PAIR_W    = VT_PROD_W + 1;
  localparam int VT_SUM_W     = VT_PROD_W + 2;

  typedef logic signed [VT_WORD_W-1:0] vt_word_t;

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_XFORM4 = 2'd1,
    OP_XFORM3 = 2'd2
  } vt_op_t;

  localparam vt_word_t VT_WORD_MAX = {1'b0, {(VT_WORD_W-1){1'b1}}};
  localparam vt_word_t VT_WORD_MIN = {1'b1, {(VT_WORD_W-1){1'b0}}};

  // Pipeline advance enables from the top level to each lane.
  typedef struct packed {
    logic mul_en;   // capture products of an accepted transform item
    logic add_en;   // capture pair sums
  } vt_ctl_t;

endpackage

/* sv/vt_lane.sv */
// vt_lane: one output column of the transform: four multipliers, pair adders,
// final sum, shift and saturate. Depends on vt_pkg.
module vt_lane #(
  parameter int FRAC_BITS = vt_pkg::VT_FRAC_BITS
) (
  input  logic             clk,
  input  vt_pkg::vt_ctl_t  ctl,
  input  vt_pkg::vt_word_t vec  [vt_pkg::VT_DIM],
  input  vt_pkg::vt_word_t col  [vt_pkg::VT_DIM],
  output vt_pkg::vt_word_t res,
  output logic             sat
);
  import vt_pkg::*;

  logic signed [VT_PROD_W-1:0] prod_r [VT_DIM];
  logic signed [VT_PAIR_W-1:0] pair_r [2];
  logic signed [VT_SUM_W-1:0]  sum;
  logic signed [VT_SUM_W-1:0]  shifted;
  logic                        fits;

  // stage 1: products, full width
  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      for (int i = 0; i < VT_DIM; i++) begin
        prod_r[i] <= VT_PROD_W'(vec[i]) * VT_PROD_W'(col[i]);
      end
    end
  end

  // stage 2: pair sums
  always_ff @(posedge clk) begin
    if (ctl.add_en) begin
      pair_r[0] <= VT_PAIR_W'(prod_r[0]) + VT_PAIR_W'(prod_r[1]);
      pair_r[1] <= VT_PAIR_W'(prod_r[2]) + VT_PAIR_W'(prod_r[3]);
    end
  end

  // final sum, floor shift, clamp
  always_comb begin
    sum     = VT_SUM_W'(pair_r[0]) + VT_SUM_W'(pair_r[1]);
    shifted = sum >>> FRAC_BITS;
    fits    = (&shifted[VT_SUM_W-1:VT_WORD_W-1]) | ~(|shifted[VT_SUM_W-1:VT_WORD_W-1]);
    sat     = ~fits;
    if (fits) begin
      res = shifted[VT_WORD_W-1:0];
    end else if (sum[VT_SUM_W-1]) begin
      res = VT_WORD_MIN;
    end else begin
      res = VT_WORD_MAX;
    end
  end

endmodule

/* sv/vt_merge.sv */
// vt_merge: output register; gathers the four lane results and ORs the
// clamp flags into one item. Depends on vt_pkg.
module vt_merge (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             lane_valid,
  input  vt_pkg::vt_word_t lane_res [vt_pkg::VT_DIM],
  input  logic             lane_sat [vt_pkg::VT_DIM],
  output logic             take,
  output logic             out_valid,
  input  logic             out_stall,
  output vt_pkg::vt_word_t out_x,
  output vt_pkg::vt_word_t out_y,
  output vt_pkg::vt_word_t out_z,
  output vt_pkg::vt_word_t out_w,
  output logic             out_saturated
);
  import vt_pkg::*;

  logic out_valid_r;
  logic any_sat;

  assign take      = ~out_valid_r | ~out_stall;
  assign out_valid = out_valid_r;
  assign any_sat   = lane_sat[0] | lane_sat[1] | lane_sat[2] | lane_sat[3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (take) begin
      out_valid_r <= lane_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take && lane_valid) begin
      out_x         <= lane_res[0];
      out_y         <= lane_res[1];
      out_z         <= lane_res[2];
      out_w         <= lane_res[3];
      out_saturated <= any_sat;
    end
  end

endmodule

/* sv/vertex_transform_4x4.sv */
// vertex_transform_4x4: top level of the row-vector by 4x4 matrix transform.
// Depends on vt_pkg, vt_lane and vt_merge.
//
// Keeps a 4x4 signed fixed-point matrix (FRAC_BITS fraction bits, identity
// after reset) and transforms row vectors: out_j = sum_i v_i * M[i][j]. A
// load item (opcode 0) writes one element, row*4+column, and gives no result;
// opcode 1 transforms (x,y,z,w), opcode 2 transforms (x,y,z) with w = 1.0;
// opcode 3 is dropped. Throughput is one item per clock while in_stall is
// low: four column lanes with four 32x32 multipliers each (sixteen in all)
// take a new vector every unstalled cycle. From input accept to out_valid
// an item passes the product register, the pair-sum register, then the
// output register, which is fed by the final add, floor shift and clamp.
// Each component saturates on its own and out_saturated flags any clamp. A
// load takes effect for the very next transform item. in_stall rises only
// when all three stages hold items and the consumer stalls.
module vertex_transform_4x4 #(
  parameter int FRAC_BITS = vt_pkg::VT_FRAC_BITS
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [1:0]       in_opcode,
  input  logic [3:0]       in_element_index,
  input  vt_pkg::vt_word_t in_element_value,
  input  vt_pkg::vt_word_t in_x,
  input  vt_pkg::vt_word_t in_y,
  input  vt_pkg::vt_word_t in_z,
  input  vt_pkg::vt_word_t in_w,
  output logic             out_valid,
  input  logic             out_stall,
  output vt_pkg::vt_word_t out_x,
  output vt_pkg::vt_word_t out_y,
  output vt_pkg::vt_word_t out_z,
  output vt_pkg::vt_word_t out_w,
  output logic             out_saturated
);
  import vt_pkg::*;

  localparam int       N_ELEM = VT_DIM * VT_DIM;
  localparam vt_word_t ONE    = VT_WORD_W'(64'd1 << FRAC_BITS);

  vt_word_t mat_r [N_ELEM];
  vt_op_t   op;
  logic     accept;
  logic     is_load;
  logic     is_xform;
  logic     mul_v_r;
  logic     add_v_r;
  logic     take;        // output register can load
  logic     add_rdy;
  logic     mul_rdy;
  vt_ctl_t  ctl;
  vt_word_t vec      [VT_DIM];
  vt_word_t lane_res [VT_DIM];
  logic     lane_sat [VT_DIM];

  assign op = vt_op_t'(in_opcode);

  always_comb begin
    is_load  = 1'b0;
    is_xform = 1'b0;
    unique case (op)
      OP_LOAD:              is_load  = 1'b1;
      OP_XFORM4, OP_XFORM3: is_xform = 1'b1;
      default:              ;   // unused opcode: no effect
    endcase
  end

  // stage ready chain, output side first
  assign add_rdy  = ~add_v_r | take;
  assign mul_rdy  = ~mul_v_r | add_rdy;
  assign in_stall = ~mul_rdy;
  assign accept   = in_valid & mul_rdy;

  assign ctl.mul_en = accept & is_xform;
  assign ctl.add_en = mul_v_r & add_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_v_r <= 1'b0;
      add_v_r <= 1'b0;
    end else begin
      if (mul_rdy) mul_v_r <= accept & is_xform;
      if (add_rdy) add_v_r <= mul_v_r;
    end
  end

  // matrix store, identity after reset; products sample it at accept,
  // so a load is seen by the next transform item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < N_ELEM; k++) begin
        mat_r[k] <= ((k % (VT_DIM + 1)) == 0) ? ONE : '0;
      end
    end else if (accept && is_load) begin
      mat_r[in_element_index] <= in_element_value;
    end
  end

  // 3-vector: w = 1.0, so the bottom row passes as M[3][j] << FRAC_BITS
  assign vec[0] = in_x;
  assign vec[1] = in_y;
  assign vec[2] = in_z;
  assign vec[3] = (op == OP_XFORM3) ? ONE : in_w;

  for (genvar j = 0; j < VT_DIM; j++) begin : g_lane
    vt_word_t col [VT_DIM];
    for (genvar i = 0; i < VT_DIM; i++) begin : g_col
      assign col[i] = mat_r[i * VT_DIM + j];
    end
    vt_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
      .clk (clk),
      .ctl (ctl),
      .vec (vec),
      .col (col),
      .res (lane_res[j]),
      .sat (lane_sat[j])
    );
  end

  vt_merge u_merge (
    .clk           (clk),
    .rst_n         (rst_n),
    .lane_valid    (add_v_r),
    .lane_res      (lane_res),
    .lane_sat      (lane_sat),
    .take          (take),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_x         (out_x),
    .out_y         (out_y),
    .out_z         (out_z),
    .out_w         (out_w),
    .out_saturated (out_saturated)
  );

endmodule

/* sv/vt_checker.sv */
// vt_checker: port-level assertions for vertex_transform_4x4, bound to the
// top level below. Depends on vt_pkg.
module vt_checker (
  input logic             clk,
  input logic             rst_n,
  input logic             in_stall,
  input logic             out_valid,
  input logic             out_stall,
  input vt_pkg::vt_word_t out_x,
  input vt_pkg::vt_word_t out_y,
  input vt_pkg::vt_word_t out_z,
  input vt_pkg::vt_word_t out_w,
  input logic             out_saturated
);
  import vt_pkg::*;

  // a result held by the consumer stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("out_valid dropped while stalled");

  // input backs up only when the output is full and stalled
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("in_stall without a stalled output item");

  // a clamped item shows at least one rail value
  a_sat_rail: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_saturated |->
      (out_x == VT_WORD_MIN || out_x == VT_WORD_MAX ||
       out_y == VT_WORD_MIN || out_y == VT_WORD_MAX ||
       out_z == VT_WORD_MIN || out_z == VT_WORD_MAX ||
       out_w == VT_WORD_MIN || out_w == VT_WORD_MAX))
    else $error("saturated flag without a clamped component");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result offered right after reset");

endmodule

bind vertex_transform_4x4 vt_checker u_vt_checker (.*);
